[rtl/core/indexed_sequence_store_defines.svh]
// Assertion macros for the indexed sequence store.
`ifndef INDEXED_SEQUENCE_STORE_DEFINES_SVH
`define INDEXED_SEQUENCE_STORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define ISS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define ISS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/iss_pkg.sv]
`timescale 1ns / 1ps
package iss_pkg;

  localparam int unsigned DEPTH_DEF     = 64;
  localparam int unsigned WORD_BITS_DEF = 32;
  localparam int unsigned DATA_BITS     = 32;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_GET    = 2'd2,
    KIND_SET    = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2,
    STATUS_EMPTY = 2'd3
  } status_e;

endpackage

[rtl/core/indexed_sequence_store.sv]
`timescale 1ns / 1ps
// Ordered sequence of up to DEPTH signed words held in one single-port-write RAM.
// Assert start while busy is low to hand in an item (insert, delete, get or set);
// exactly one result follows, shown for a single cycle with result_valid_o high.
// The receiver cannot stall: capture the result in that cycle. busy stays high
// from the accept until the cycle after the result. Insert and delete move one
// entry per cycle through the RAM read/write-back loop, shifting the entries from
// the position to the end; get reads one entry, set writes one, and any item that
// is flagged and ignored goes straight to its result without touching the RAM. No
// clearing pass after reset: the store is empty and ready at once.
module indexed_sequence_store #(
  parameter int unsigned DEPTH     = iss_pkg::DEPTH_DEF,
  parameter int unsigned WORD_BITS = iss_pkg::WORD_BITS_DEF,
  localparam int unsigned LenBits  = $clog2(DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          kind_i,
  input  logic [LenBits-1:0]                  position_i,
  input  logic signed [iss_pkg::DATA_BITS-1:0] data_in_i,
  output logic                                result_valid_o,
  output logic signed [iss_pkg::DATA_BITS-1:0] data_out_o,
  output logic [LenBits-1:0]                  length_o,
  output logic [1:0]                          status_o
);

  import iss_pkg::*;

  localparam int unsigned AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned ExtBits = WORD_BITS + DATA_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [LenBits-1:0]   count_q, count_d;
  logic [LenBits-1:0]   n_q, n_d;
  logic [AW-1:0]        rd_q, rd_d;
  logic [AW-1:0]        prev_q;
  logic                 rv_q;
  kind_e                kind_q, kind_d;
  status_e              status_q, status_d;
  logic [AW-1:0]        pos_q, pos_d;
  logic [WORD_BITS-1:0] word_q, word_d;
  logic [DATA_BITS-1:0] dout_q, dout_d;

  logic                 accept;
  logic [LenBits-1:0]   cnt_m1;
  logic signed [ExtBits-1:0] in_ext;
  logic signed [ExtBits-1:0] rd_ext;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic                 ram_re;
  logic [WORD_BITS-1:0] ram_rdata;
  logic                 capture;

  iss_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_iss_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (rd_q),
    .rdata_o (ram_rdata)
  );

  assign accept = start && (state_q == S_IDLE);
  assign busy   = (state_q != S_IDLE);
  assign cnt_m1 = count_q - 1'b1;
  assign in_ext = ExtBits'(data_in_i);
  assign rd_ext = ExtBits'(signed'(ram_rdata));
  assign capture = rv_q && (kind_q != KIND_INSERT) && (prev_q == pos_q);

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    n_d      = n_q;
    rd_d     = rd_q;
    kind_d   = kind_q;
    status_d = status_q;
    pos_d    = pos_q;
    word_d   = word_q;
    dout_d   = dout_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = word_q;
    ram_re    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          kind_d   = kind_e'(kind_i);
          pos_d    = position_i[AW-1:0];
          word_d   = in_ext[WORD_BITS-1:0];
          dout_d   = '0;
          status_d = STATUS_OK;
          n_d      = '0;
          rd_d     = position_i[AW-1:0];
          case (kind_e'(kind_i))
            KIND_INSERT: begin
              if (position_i > count_q) begin
                status_d = STATUS_RANGE;
              end else if (count_q == LenBits'(DEPTH)) begin
                status_d = STATUS_FULL;
              end else begin
                n_d     = count_q - position_i;
                rd_d    = cnt_m1[AW-1:0];
                count_d = count_q + 1'b1;
              end
            end
            KIND_DELETE: begin
              if (count_q == '0) begin
                status_d = STATUS_EMPTY;
              end else if (position_i >= count_q) begin
                status_d = STATUS_RANGE;
              end else begin
                n_d     = count_q - position_i;
                count_d = cnt_m1;
              end
            end
            KIND_GET: begin
              if (position_i >= count_q) begin
                status_d = STATUS_RANGE;
                dout_d   = '1;
              end else begin
                n_d = LenBits'(1);
              end
            end
            default: begin
              if (position_i >= count_q) begin
                status_d = STATUS_RANGE;
              end
            end
          endcase
          state_d = (status_d == STATUS_OK) ? S_RUN : S_FIN;
        end
      end
      S_RUN: begin
        if (n_q != '0) begin
          ram_re = 1'b1;
          n_d    = n_q - 1'b1;
          rd_d   = (kind_q == KIND_INSERT) ? AW'(rd_q - 1'b1) : AW'(rd_q + 1'b1);
        end
        if (rv_q) begin
          ram_wdata = ram_rdata;
          if (kind_q == KIND_INSERT) begin
            ram_we    = 1'b1;
            ram_waddr = AW'(prev_q + 1'b1);
          end else if (capture) begin
            dout_d = rd_ext[DATA_BITS-1:0];
          end else begin
            ram_we    = 1'b1;
            ram_waddr = AW'(prev_q - 1'b1);
          end
        end
        if ((n_q == '0) && !rv_q) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        ram_we  = (status_q == STATUS_OK) &&
                  ((kind_q == KIND_INSERT) || (kind_q == KIND_SET));
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      n_q     <= '0;
      rv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      n_q     <= n_d;
      rv_q    <= (state_q == S_RUN) && (n_q != '0);
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q     <= rd_d;
    prev_q   <= rd_q;
    kind_q   <= kind_d;
    status_q <= status_d;
    pos_q    <= pos_d;
    word_q   <= word_d;
    dout_q   <= dout_d;
  end

  assign result_valid_o = (state_q == S_FIN);
  assign data_out_o     = signed'(dout_q);
  assign length_o       = count_q;
  assign status_o       = status_q;

endmodule

[rtl/core/iss_ram.sv]
`timescale 1ns / 1ps
module iss_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/iss_checker.sv]
`timescale 1ns / 1ps
`include "indexed_sequence_store_defines.svh"
module iss_checker #(
  parameter int unsigned DEPTH    = iss_pkg::DEPTH_DEF,
  localparam int unsigned LenBits = $clog2(DEPTH + 1)
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start,
  input logic               busy,
  input logic               result_valid_o,
  input logic [LenBits-1:0] length_o,
  input logic [1:0]         status_o
);

  import iss_pkg::*;

  `ISS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `ISS_ASSERT_NOW(a_result_busy, result_valid_o, busy, "result shown while not busy")
  `ISS_ASSERT_NEXT(a_result_once, result_valid_o, !result_valid_o && !busy, "result not single")
  `ISS_ASSERT_NOW(a_full_len, result_valid_o && (status_o == STATUS_FULL),
                  length_o == LenBits'(DEPTH), "full status with short length")
  `ISS_ASSERT_NOW(a_len_max, result_valid_o, length_o <= LenBits'(DEPTH), "length above depth")

endmodule

bind indexed_sequence_store iss_checker #(.DEPTH(DEPTH)) u_iss_checker (.*);
